@@ rtl/lax_friedrichs_net_flux_core_macros.svh @@
// assertion macros for the lax-friedrichs net flux block
// no dependencies; the including module must have clk and rst_n
`ifndef LAX_FRIEDRICHS_NET_FLUX_CORE_MACROS_SVH
`define LAX_FRIEDRICHS_NET_FLUX_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define LFNF_CHECK(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfnf check failed");

// next-cycle implication, off during reset
`define LFNF_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfnf next-cycle check failed");

`endif

@@ rtl/lfnf_pkg.sv @@
// types and fixed constants for the lax-friedrichs net flux block
// no dependencies; used by lfnf_div and lax_friedrichs_net_flux_core
package lfnf_pkg;

    localparam int DATA_W  = 32;
    localparam int WIDTH_W = 31;
    localparam int NUM_W   = 48;
    localparam int QUO_W   = 31;
    localparam int QCNT_W  = $clog2(QUO_W + 1);

    localparam logic [0:0] REG_WAVE_SPEED      = 1'b0;
    localparam logic [0:0] REG_COMPONENT_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FLUX,
        ST_DIFF,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic                 neg;
        logic [NUM_W-1:0]     num;
        logic [WIDTH_W-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DATA_W-1:0]    quot;
    } div_rsp_t;

endpackage

@@ rtl/lax_friedrichs_net_flux_core.sv @@
// top level of the lax-friedrichs net flux block
// depends on lfnf_pkg, lfnf_div and lax_friedrichs_net_flux_core_macros.svh
//
// usage
//  - input channel (in_valid / in_stall): one conserved component of one
//    interface per transfer; components of an interface come in order,
//    row_start marks the first interface of a row
//  - output channel (out_valid / out_stall): at most one result per input
//    transfer, none for items of a row's first interface
//  - config port: cfg_write with cfg_index 0 = wave_speed, 1 = component_count;
//    write only while the block is idle
//  - one item is in flight at a time; in_stall is high from the transfer
//    until the item is finished
//  - items with no result pass ST_MUL, ST_FLUX and ST_DIFF and go back to idle;
//    items with a result then run the 31-step restoring divider (an
//    overflowing quotient skips the steps) before ST_OUT loads the output
//  - zero cell width skips the divider: net_flux 0, width_error 1
//  - a result waits in the output register while out_stall is high; the next
//    item runs meanwhile and holds in its last state until the register frees
//  - reset: wave_speed 1.0, one component, counter 0, first interface
//    pending, output empty; the flux memory is not cleared
module lax_friedrichs_net_flux_core
#(
    parameter int MAX_COMPONENTS = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_write,
    input  logic [0:0]                    cfg_index,
    input  logic [30:0]                   cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [31:0]            q_minus,
    input  logic signed [31:0]            q_plus,
    input  logic signed [31:0]            f_minus,
    input  logic signed [31:0]            f_plus,
    input  logic [30:0]                   cell_width,
    input  logic                          row_start,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [31:0]            net_flux,
    output logic [2:0]                    component_index,
    output logic                          last_component,
    output logic                          width_error
);

    localparam int IDX_W = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam logic [7:0] MAX_CNT = 8'(MAX_COMPONENTS);

    // configuration
    logic [30:0]                  wave_speed_reg;
    logic [3:0]                   comp_count_reg;

    // control state
    lfnf_pkg::state_t             state_reg;
    lfnf_pkg::state_t             state_next;
    logic [IDX_W-1:0]             cnt_reg;
    logic                         pend_reg;
    logic                         out_valid_reg;

    // item payload
    logic signed [32:0]           s_reg;
    logic signed [32:0]           d_reg;
    logic [30:0]                  dx_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic                         last_reg;
    logic                         emit_reg;
    logic signed [64:0]           prod_reg;
    logic signed [31:0]           flux_reg;
    logic signed [31:0]           prev_rd_reg;

    // output register
    logic signed [31:0]           net_flux_reg;
    logic [2:0]                   comp_idx_reg;
    logic                         last_out_reg;
    logic                         err_out_reg;

    // previous interface flux, one entry per component
    logic signed [31:0]           flux_mem [MAX_COMPONENTS];

    // transfer decode
    logic                         in_xfer;
    logic                         out_xfer;
    logic                         out_free;

    // control outputs of the state machine
    logic                         div_start;
    logic                         mem_wr;
    logic                         out_load;

    // current component
    logic [7:0]                   eff_count;
    logic [7:0]                   cnt_ext;
    logic [7:0]                   cur_ext;
    logic                         cur_last;
    logic                         pend_eff;

    // arithmetic
    logic signed [65:0]           flux_sum;
    logic signed [65:0]           flux_shr;
    logic signed [31:0]           flux_sat;
    logic signed [32:0]           diff;
    logic [32:0]                  diff_mag;

    lfnf_pkg::div_req_t           div_req;
    lfnf_pkg::div_rsp_t           div_rsp;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // effective component count: 0 acts as 1, clamp at the memory depth
    always_comb
    begin
        if (comp_count_reg == 4'd0)
            eff_count = 8'd1;
        else if (8'(comp_count_reg) > MAX_CNT)
            eff_count = MAX_CNT;
        else
            eff_count = 8'(comp_count_reg);
        cnt_ext  = 8'(cnt_reg);
        // counter past a lowered count acts as the last component
        cur_ext  = (cnt_ext >= eff_count) ? (eff_count - 8'd1) : cnt_ext;
        cur_last = (cur_ext == (eff_count - 8'd1));
        pend_eff = pend_reg || row_start;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_speed_reg <= 31'd65536;
            comp_count_reg <= 4'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lfnf_pkg::REG_WAVE_SPEED:      wave_speed_reg <= cfg_data;
                lfnf_pkg::REG_COMPONENT_COUNT: comp_count_reg <= cfg_data[3:0];
                default:                       ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lfnf_pkg::ST_IDLE: if (in_xfer) state_next = lfnf_pkg::ST_MUL;
            lfnf_pkg::ST_MUL:  state_next = lfnf_pkg::ST_FLUX;
            lfnf_pkg::ST_FLUX: state_next = lfnf_pkg::ST_DIFF;
            lfnf_pkg::ST_DIFF:
            begin
                if (!emit_reg)
                    state_next = lfnf_pkg::ST_IDLE;
                else if (dx_reg == '0)
                    state_next = lfnf_pkg::ST_OUT;
                else
                    state_next = lfnf_pkg::ST_DIV;
            end
            lfnf_pkg::ST_DIV:  if (div_rsp.done) state_next = lfnf_pkg::ST_OUT;
            lfnf_pkg::ST_OUT:  if (out_free) state_next = lfnf_pkg::ST_IDLE;
            default:           state_next = lfnf_pkg::ST_IDLE;
        endcase
    end

    // state machine outputs
    always_comb
    begin
        in_stall  = (state_reg != lfnf_pkg::ST_IDLE);
        mem_wr    = (state_reg == lfnf_pkg::ST_DIFF);
        div_start = (state_reg == lfnf_pkg::ST_DIFF) && emit_reg && (dx_reg != '0);
        out_load  = (state_reg == lfnf_pkg::ST_OUT) && out_free;
    end

    // control registers; counter and pending mark move on at the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfnf_pkg::ST_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer)
            begin
                cnt_reg  <= cur_last ? '0 : IDX_W'(cur_ext + 8'd1);
                pend_reg <= cur_last ? 1'b0 : pend_eff;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_xfer)
                out_valid_reg <= 1'b0;
        end
    end

    // capture the item; sum and difference are formed on the way in
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s_reg    <= 33'(f_minus) + 33'(f_plus);
            d_reg    <= 33'(q_plus) - 33'(q_minus);
            dx_reg   <= cell_width;
            idx_reg  <= IDX_W'(cur_ext);
            last_reg <= cur_last;
            emit_reg <= !pend_eff;
        end
        if (state_reg == lfnf_pkg::ST_MUL)
            prod_reg <= $signed({1'b0, wave_speed_reg}) * d_reg;
        if (state_reg == lfnf_pkg::ST_FLUX)
            flux_reg <= flux_sat;
    end

    // flux memory: read at the transfer, write back after the flux is known;
    // one item at a time, so a read never meets a pending write
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            prev_rd_reg <= flux_mem[IDX_W'(cur_ext)];
        if (mem_wr)
            flux_mem[idx_reg] <= flux_reg;
    end

    // interface flux: floor((s*2^16 - alpha*d + 2^15) / 2^17), saturated
    always_comb
    begin
        flux_sum = (66'(s_reg) <<< 16) + 66'sd32768 - 66'(prod_reg);
        flux_shr = flux_sum >>> 17;
        if (flux_shr > 66'sd2147483647)
            flux_sat = 32'sh7FFF_FFFF;
        else if (flux_shr < -66'sd2147483648)
            flux_sat = 32'sh8000_0000;
        else
            flux_sat = flux_shr[31:0];
    end

    // net flux numerator: (previous - current) * 2^16, sign and magnitude
    always_comb
    begin
        diff     = 33'(prev_rd_reg) - 33'(flux_reg);
        diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
        div_req.start = div_start;
        div_req.neg   = diff[32];
        div_req.num   = {diff_mag[31:0], 16'h0000};
        div_req.den   = dx_reg;
    end

    lfnf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            net_flux_reg <= (dx_reg == '0) ? 32'sd0 : $signed(div_rsp.quot);
            comp_idx_reg <= 3'(8'(idx_reg));
            last_out_reg <= last_reg;
            err_out_reg  <= (dx_reg == '0);
        end
    end

    assign out_valid       = out_valid_reg;
    assign net_flux        = net_flux_reg;
    assign component_index = comp_idx_reg;
    assign last_component  = last_out_reg;
    assign width_error     = err_out_reg;

`include "lax_friedrichs_net_flux_core_macros.svh"

    `LFNF_CHECK(a_div_done_in_div, div_rsp.done, state_reg == lfnf_pkg::ST_DIV)
    `LFNF_CHECK(a_err_zero, out_valid_reg && err_out_reg, net_flux_reg == 32'sd0)
    `LFNF_CHECK(a_cnt_range, 1'b1, 8'(cnt_reg) < MAX_CNT)
    `LFNF_CHECK_NEXT(a_xfer_starts, in_xfer, state_reg == lfnf_pkg::ST_MUL)

endmodule

@@ rtl/lfnf_div.sv @@
// radix-2 restoring divider: signed result of magnitude / width, saturated
// depends on lfnf_pkg
module lfnf_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  lfnf_pkg::div_req_t req,
    output lfnf_pkg::div_rsp_t rsp
);

    logic                              busy_reg;
    logic                              done_reg;
    logic                              ovf_reg;
    logic                              neg_reg;
    logic [lfnf_pkg::QCNT_W-1:0]       cnt_reg;
    logic [lfnf_pkg::QUO_W-1:0]        rem_reg;
    logic [lfnf_pkg::QUO_W-1:0]        quo_reg;
    logic [lfnf_pkg::WIDTH_W-1:0]      den_reg;

    logic [lfnf_pkg::WIDTH_W-1:0]      num_hi;
    logic signed [lfnf_pkg::QUO_W+1:0] trial;
    logic                              qbit;

    // top part of the numerator; quotient >= 2^31 exactly when it is >= den
    assign num_hi = lfnf_pkg::WIDTH_W'(req.num[lfnf_pkg::NUM_W-1:lfnf_pkg::QUO_W]);

    assign trial = $signed({1'b0, rem_reg, quo_reg[lfnf_pkg::QUO_W-1]})
                 - $signed({2'b00, den_reg});
    assign qbit  = !trial[lfnf_pkg::QUO_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                if (num_hi >= req.den)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= lfnf_pkg::QCNT_W'(lfnf_pkg::QUO_W);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - lfnf_pkg::QCNT_W'(1);
                if (cnt_reg == lfnf_pkg::QCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            ovf_reg <= (num_hi >= req.den);
            neg_reg <= req.neg;
            den_reg <= req.den;
            rem_reg <= num_hi;
            quo_reg <= req.num[lfnf_pkg::QUO_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? trial[lfnf_pkg::QUO_W-1:0]
                            : {rem_reg[lfnf_pkg::QUO_W-2:0], quo_reg[lfnf_pkg::QUO_W-1]};
            quo_reg <= {quo_reg[lfnf_pkg::QUO_W-2:0], qbit};
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        if (ovf_reg)
            rsp.quot = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else if (neg_reg)
            rsp.quot = -{1'b0, quo_reg};
        else
            rsp.quot = {1'b0, quo_reg};
    end

endmodule
